// ===== hw/rtl/mser_pkg.sv =====
// ----------------------------------------------------------------------------
// mser_pkg: shared types and constants for the edge relaxation engine
// Holds the command codes, state encoding, register indexes and the
// distance value that stands for infinity.
// ----------------------------------------------------------------------------
package mser_pkg;

   // Command codes carried in the low bits of req_tdata.
   localparam logic [2:0] CMD_CLEAR      = 3'd0;
   localparam logic [2:0] CMD_SET_SOURCE = 3'd1;
   localparam logic [2:0] CMD_RELAX      = 3'd2;
   localparam logic [2:0] CMD_END_ROUND  = 3'd3;
   localparam logic [2:0] CMD_READ       = 3'd4;

   // Configuration register indexes.
   localparam logic [7:0] REG_VERTICES = 8'd0;
   localparam logic [7:0] REG_SOURCES  = 8'd1;

   // Distance that stands for an unreached vertex.
   localparam logic signed [31:0] DIST_INF = 32'sh3FFF_FFFF;

   // Controller states.
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_CLEAR,
      ST_ROUND,
      ST_FINISH
   } state_type;

endpackage

// ===== hw/rtl/multi_source_edge_relaxation.sv =====
// ----------------------------------------------------------------------------
// multi_source_edge_relaxation: multi-source Bellman-Ford relaxation engine
// Two row memories (current and next bank) hold one row per vertex with every
// source column and that vertex's active flag; commands read, modify and write
// rows back.
// ----------------------------------------------------------------------------
// Usage:
// Commands enter on the req_ stream (one item each) and every command gives
// exactly one item on the rsp_ stream. The csr_ channel writes the vertex and
// source counts and is always ready; write it only while the block is idle.
// Set source, relax and read first read the row, then modify it with write
// back and load the result register in the same cycle; one item is worked
// on at a time, so a new command is taken only once the last one is through.
// Clear walks the vertices in use at one row a cycle; end round reads and
// writes one row a cycle through a two-stage sweep, counting the vertices
// that stay active. After reset a clearing pass writes infinity to all
// MAX_VERTICES rows of both banks, during which req_tready is low.
// A stalled receiver holds the result register; the block may accept one more
// item, which then waits in its write-back cycle until the register frees.
// ----------------------------------------------------------------------------
module multi_source_edge_relaxation #(
   parameter int MAX_VERTICES = 1024,
   parameter int MAX_SOURCES  = 4
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: command[2:0], src_vertex[12:3], dst_vertex[22:13],
   //            edge_weight[38:23], source_index[40:39], zero fill[47:41]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   // rsp_tdata: read_distance[31:0], improved[32], active_count[43:33],
   //            all_settled[44], zero fill[47:45]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [10:0] csr_data
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int SW = $clog2(MAX_SOURCES + 1);
   localparam int RW = MAX_SOURCES * 32 + 1;

   // Row layout: column j in bits [32*j +: 32], active flag in the top bit.
   typedef logic [RW-1:0] row_type;

   // Configuration registers.
   logic [10:0] vert_cfg_ff;
   logic [2:0]  src_cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vert_cfg_ff <= 11'd1024;
         src_cfg_ff  <= 3'd4;
      end else if (csr_valid) begin
         if (csr_index == mser_pkg::REG_VERTICES) begin
            vert_cfg_ff <= csr_data;
         end else if (csr_index == mser_pkg::REG_SOURCES) begin
            src_cfg_ff <= csr_data[2:0];
         end
      end
   end

   // Live counts clamp to the built sizes.
   logic [CW-1:0] nv;
   logic [SW-1:0] ns;
   assign nv = (32'(vert_cfg_ff) > 32'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vert_cfg_ff);
   assign ns = (32'(src_cfg_ff) > 32'(MAX_SOURCES)) ? SW'(MAX_SOURCES) : SW'(src_cfg_ff);

   // Input field unpacking.
   logic [2:0]  in_cmd;
   logic [9:0]  in_src;
   logic [9:0]  in_dst;
   assign in_cmd = req_tdata[2:0];
   assign in_src = req_tdata[12:3];
   assign in_dst = req_tdata[22:13];

   // Controller registers.
   mser_pkg::state_type state_ff, state_in;
   logic [2:0]          cmd_ff;
   logic [9:0]          sv_ff;
   logic [9:0]          dv_ff;
   logic signed [15:0]  w_ff;
   logic [1:0]          col_ff;
   logic [CW-1:0]       idx_ff, idx_in;
   logic                wr_pend_ff, wr_pend_in;
   logic [AW-1:0]       wr_idx_ff;
   logic [CW-1:0]       count_ff, count_in;

   logic accept;
   logic out_free;
   logic load_rsp;
   assign req_tready = (state_ff == mser_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   logic rsp_valid_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Memory ports.
   logic          cur_we, nxt_we, cur_re, nxt_re;
   logic [AW-1:0] cur_waddr, nxt_waddr, cur_raddr, nxt_raddr;
   row_type       cur_wdata, nxt_wdata;
   row_type       cur_rdata_ff, nxt_rdata_ff;
   row_type       cur_mem [MAX_VERTICES];
   row_type       nxt_mem [MAX_VERTICES];

   always_ff @(posedge clock) begin
      if (cur_we) begin
         cur_mem[cur_waddr] <= cur_wdata;
      end
      if (cur_re) begin
         cur_rdata_ff <= cur_mem[cur_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (nxt_we) begin
         nxt_mem[nxt_waddr] <= nxt_wdata;
      end
      if (nxt_re) begin
         nxt_rdata_ff <= nxt_mem[nxt_raddr];
      end
   end

   // Range checks for the held command.
   logic sv_ok, dv_ok, col_ok, src_active, relax_ok;
   assign sv_ok      = 32'(sv_ff) < 32'(nv);
   assign dv_ok      = 32'(dv_ff) < 32'(nv);
   assign col_ok     = 32'(col_ff) < 32'(ns);
   assign src_active = cur_rdata_ff[RW-1];
   assign relax_ok   = sv_ok && dv_ok && src_active;

   // Infinity row with the active flag cleared.
   row_type inf_row;
   always_comb begin
      inf_row = '0;
      for (int j = 0; j < MAX_SOURCES; j++) begin
         inf_row[32*j +: 32] = mser_pkg::DIST_INF;
      end
   end

   // Relax: saturated candidate per column, keep the smaller one.
   row_type          relax_row;
   logic             improved;
   logic signed [32:0] sum;
   logic signed [31:0] cand;
   always_comb begin
      relax_row = nxt_rdata_ff;
      improved  = 1'b0;
      sum       = '0;
      cand      = '0;
      for (int j = 0; j < MAX_SOURCES; j++) begin
         sum = {cur_rdata_ff[32*j+31], cur_rdata_ff[32*j +: 32]} + 33'(w_ff);
         if (sum[32] != sum[31]) begin
            cand = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         end else begin
            cand = sum[31:0];
         end
         if ((32'(j) < 32'(ns)) && (cand < $signed(nxt_rdata_ff[32*j +: 32]))) begin
            relax_row[32*j +: 32] = cand;
            improved = 1'b1;
         end
      end
      relax_row[RW-1] = nxt_rdata_ff[RW-1] | improved;
   end

   // Set source: zero the chosen column in both banks, set the current active flag.
   row_type set_cur_row, set_nxt_row;
   logic [31:0] read_val;
   always_comb begin
      set_cur_row = cur_rdata_ff;
      set_nxt_row = nxt_rdata_ff;
      read_val    = mser_pkg::DIST_INF;
      for (int j = 0; j < MAX_SOURCES; j++) begin
         if (32'(j) == 32'(col_ff)) begin
            set_cur_row[32*j +: 32] = '0;
            set_nxt_row[32*j +: 32] = '0;
            if (sv_ok && col_ok) begin
               read_val = cur_rdata_ff[32*j +: 32];
            end
         end
      end
      set_cur_row[RW-1] = 1'b1;
   end

   // End round: copy live columns and the flag forward, clear next flag.
   row_type round_cur_row, round_nxt_row;
   always_comb begin
      round_cur_row = cur_rdata_ff;
      for (int j = 0; j < MAX_SOURCES; j++) begin
         if (32'(j) < 32'(ns)) begin
            round_cur_row[32*j +: 32] = nxt_rdata_ff[32*j +: 32];
         end
      end
      round_cur_row[RW-1] = nxt_rdata_ff[RW-1];
      round_nxt_row       = nxt_rdata_ff;
      round_nxt_row[RW-1] = 1'b0;
   end

   // Next-state logic.
   logic round_rd;
   assign round_rd = (state_ff == mser_pkg::ST_ROUND) && (idx_ff < nv);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mser_pkg::ST_INIT: begin
            if (idx_ff == CW'(MAX_VERTICES - 1)) begin
               state_in = mser_pkg::ST_IDLE;
            end
         end
         mser_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = mser_pkg::ST_EXEC;
            end
         end
         mser_pkg::ST_EXEC: begin
            if (cmd_ff == mser_pkg::CMD_CLEAR) begin
               state_in = mser_pkg::ST_CLEAR;
            end else if (cmd_ff == mser_pkg::CMD_END_ROUND) begin
               state_in = mser_pkg::ST_ROUND;
            end else if (out_free) begin
               state_in = mser_pkg::ST_IDLE;
            end
         end
         mser_pkg::ST_CLEAR: begin
            if (idx_ff >= nv) begin
               state_in = mser_pkg::ST_FINISH;
            end
         end
         mser_pkg::ST_ROUND: begin
            if (!round_rd && !wr_pend_ff) begin
               state_in = mser_pkg::ST_FINISH;
            end
         end
         mser_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = mser_pkg::ST_IDLE;
            end
         end
         default: state_in = mser_pkg::ST_IDLE;
      endcase
   end

   // Datapath control outputs.
   always_comb begin
      cur_we     = 1'b0;
      nxt_we     = 1'b0;
      cur_waddr  = AW'(sv_ff);
      nxt_waddr  = AW'(sv_ff);
      cur_wdata  = set_cur_row;
      nxt_wdata  = set_nxt_row;
      cur_re     = 1'b0;
      nxt_re     = 1'b0;
      cur_raddr  = AW'(in_src);
      nxt_raddr  = (in_cmd == mser_pkg::CMD_RELAX) ? AW'(in_dst) : AW'(in_src);
      idx_in     = idx_ff;
      wr_pend_in = 1'b0;
      count_in   = count_ff;
      load_rsp   = 1'b0;
      unique case (state_ff)
         mser_pkg::ST_INIT: begin
            cur_we    = 1'b1;
            nxt_we    = 1'b1;
            cur_waddr = idx_ff[AW-1:0];
            nxt_waddr = idx_ff[AW-1:0];
            cur_wdata = inf_row;
            nxt_wdata = inf_row;
            idx_in    = idx_ff + 1'b1;
         end
         mser_pkg::ST_IDLE: begin
            cur_re   = accept;
            nxt_re   = accept;
            idx_in   = '0;
            count_in = '0;
         end
         mser_pkg::ST_EXEC: begin
            if (out_free) begin
               if (cmd_ff == mser_pkg::CMD_SET_SOURCE) begin
                  cur_we = sv_ok && col_ok;
                  nxt_we = sv_ok && col_ok;
                  load_rsp = 1'b1;
               end else if (cmd_ff == mser_pkg::CMD_RELAX) begin
                  nxt_we    = relax_ok;
                  nxt_waddr = AW'(dv_ff);
                  nxt_wdata = relax_row;
                  load_rsp  = 1'b1;
               end else if (cmd_ff != mser_pkg::CMD_CLEAR &&
                            cmd_ff != mser_pkg::CMD_END_ROUND) begin
                  load_rsp = 1'b1;
               end
            end
         end
         mser_pkg::ST_CLEAR: begin
            if (idx_ff < nv) begin
               cur_we    = 1'b1;
               nxt_we    = 1'b1;
               cur_waddr = idx_ff[AW-1:0];
               nxt_waddr = idx_ff[AW-1:0];
               cur_wdata = inf_row;
               nxt_wdata = inf_row;
               idx_in    = idx_ff + 1'b1;
            end
         end
         mser_pkg::ST_ROUND: begin
            cur_re     = round_rd;
            nxt_re     = round_rd;
            cur_raddr  = idx_ff[AW-1:0];
            nxt_raddr  = idx_ff[AW-1:0];
            wr_pend_in = round_rd;
            if (round_rd) begin
               idx_in = idx_ff + 1'b1;
            end
            if (wr_pend_ff) begin
               cur_we    = 1'b1;
               nxt_we    = 1'b1;
               cur_waddr = wr_idx_ff;
               nxt_waddr = wr_idx_ff;
               cur_wdata = round_cur_row;
               nxt_wdata = round_nxt_row;
               count_in  = count_ff + CW'(nxt_rdata_ff[RW-1]);
            end
         end
         mser_pkg::ST_FINISH: begin
            load_rsp = out_free;
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mser_pkg::ST_INIT;
         idx_ff     <= '0;
         wr_pend_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         wr_pend_ff <= wr_pend_in;
         count_ff   <= count_in;
      end
   end

   // Held command fields and the round write address.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= in_cmd;
         sv_ff  <= in_src;
         dv_ff  <= in_dst;
         w_ff   <= req_tdata[38:23];
         col_ff <= req_tdata[40:39];
      end
      wr_idx_ff <= idx_ff[AW-1:0];
   end

   // Result register.
   logic [31:0] rsp_dist_ff;
   logic        rsp_impr_ff;
   logic [10:0] rsp_count_ff;
   logic        rsp_settled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_dist_ff    <= (cmd_ff == mser_pkg::CMD_READ) ? read_val : '0;
         rsp_impr_ff    <= (cmd_ff == mser_pkg::CMD_RELAX) && relax_ok && improved;
         rsp_count_ff   <= (cmd_ff == mser_pkg::CMD_END_ROUND) ? 11'(count_ff) : '0;
         rsp_settled_ff <= (cmd_ff == mser_pkg::CMD_END_ROUND) && (count_ff == '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_settled_ff, rsp_count_ff, rsp_impr_ff, rsp_dist_ff};

endmodule
